/* rtl/page_table_range_manager_assert.svh */
// Assertion macros used by the checker module of the page table range manager.
`ifndef PAGE_TABLE_RANGE_MANAGER_ASSERT_SVH
`define PAGE_TABLE_RANGE_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PTRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page table range manager: assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PTRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page table range manager: assertion failed");

`endif

/* rtl/ptrm_pkg.sv */
package ptrm_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES     = 1024;
    localparam int DIRECTORY_ENTRIES = 1024;
    localparam int TOTAL_ENTRIES     = TABLE_ENTRIES * DIRECTORY_ENTRIES;
    localparam int IDX_W             = $clog2(TOTAL_ENTRIES);

    // Field widths.
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 10;
    localparam int FRAME_W  = 20;
    localparam int ENTRY_W  = FRAME_W + 2;
    // A page count reaches 2^20, so it needs one bit more than a frame number.
    localparam int CNT_W    = 21;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_MAP  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ARG = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd2;

    typedef logic [ENTRY_W-1:0] entry_t;

endpackage

/* rtl/page_table_range_manager.sv */
// Page table range manager.
// Input channel (in_valid / in_stall) carries one request transaction: map, free or find.
// Output channel (out_valid / out_stall) returns one result transaction per request,
// holding status and, for a successful find, the start address of the free run.
// After reset the block clears its entry memory, one entry per cycle, all
// TOTAL_ENTRIES entries (1048576 with the default geometry); in_stall stays high.
// Work proceeds through the single-port entry memory, one entry per cycle:
//   map or free: one write per page, then the result register is loaded;
//   find: entries are read in order, the scan stopping at the first fitting run;
//   requests rejected by their arguments go straight to the result register.
// One request is worked on at a time; in_stall is high from acceptance until the
// block is idle again. The result sits in an output register, so the next request
// is accepted while a result still waits; a finished request whose result cannot be
// loaded because the receiver stalls waits until the output register frees up.
module page_table_range_manager
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ptrm_pkg::OP_W-1:0]       operation,
    input  logic [ptrm_pkg::ADDR_W-1:0]     virtual_address,
    input  logic [ptrm_pkg::ADDR_W-1:0]     length_bytes,
    input  logic [ptrm_pkg::ADDR_W-1:0]     physical_address,
    input  logic                            writable,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ptrm_pkg::STATUS_W-1:0]   status,
    output logic [ptrm_pkg::ADDR_W-1:0]     found_address
);
    import ptrm_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    localparam logic [IDX_W-1:0]   LAST_POS  = IDX_W'(TOTAL_ENTRIES - 1);
    localparam logic [FIELD_W-1:0] PAGE_LAST = FIELD_W'(TABLE_ENTRIES - 1);
    localparam logic [FIELD_W-1:0] DIR_LAST  = FIELD_W'(DIRECTORY_ENTRIES - 1);

    // Entry memory.
    entry_t mem [TOTAL_ENTRIES];
    entry_t mem_rdata_reg;
    logic   mem_we;
    logic   mem_re;
    entry_t mem_wdata;

    logic [2:0]          state_reg,      state_next;
    logic [IDX_W-1:0]    pos_reg,        pos_next;
    logic [CNT_W-1:0]    rem_reg,        rem_next;
    logic [FRAME_W-1:0]  frame_reg,      frame_next;
    logic                map_reg,        map_next;
    logic                writable_reg,   writable_next;
    logic [CNT_W-1:0]    want_reg,       want_next;
    logic [CNT_W-1:0]    run_reg,        run_next;
    logic                active_reg,     active_next;
    logic [FIELD_W-1:0]  start_dir_reg,  start_dir_next;
    logic [FIELD_W-1:0]  start_page_reg, start_page_next;
    logic [FIELD_W-1:0]  eval_dir_reg,   eval_dir_next;
    logic [FIELD_W-1:0]  eval_page_reg,  eval_page_next;
    logic                issue_on_reg,   issue_on_next;
    logic                rd_pend_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg,   res_addr_next;
    logic                out_valid_reg,  out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg,   out_addr_next;

    logic                in_accept;
    logic                slot_free;
    logic [CNT_W-1:0]    req_count;
    logic [ADDR_W:0]     len_round;
    logic [FIELD_W-1:0]  va_dir;
    logic [FIELD_W-1:0]  va_page;
    logic                out_of_range;
    logic [CNT_W-1:0]    start_full;
    logic [CNT_W-1:0]    run_inc;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found_address = out_addr_reg;

    // Request decoding: page count, start directory and page, and range check.
    assign len_round    = {1'b0, length_bytes} + (ADDR_W + 1)'(4095);
    assign req_count    = len_round[ADDR_W:12];
    assign va_dir       = virtual_address[31:22];
    assign va_page      = virtual_address[21:12];
    assign out_of_range = ({1'b0, va_dir} >= (FIELD_W + 1)'(DIRECTORY_ENTRIES))
                       || ({1'b0, va_page} >= (FIELD_W + 1)'(TABLE_ENTRIES));
    assign start_full   = CNT_W'(va_dir) * CNT_W'(TABLE_ENTRIES) + CNT_W'(va_page);
    assign run_inc      = run_reg + CNT_W'(1);

    // Memory port: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[pos_reg];
        end
    end

    // Sequencer for clearing, range writes, the first-fit scan and the result.
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        frame_next      = frame_reg;
        map_next        = map_reg;
        writable_next   = writable_reg;
        want_next       = want_reg;
        run_next        = run_reg;
        active_next     = active_reg;
        start_dir_next  = start_dir_reg;
        start_page_next = start_page_reg;
        eval_dir_next   = eval_dir_reg;
        eval_page_next  = eval_page_reg;
        issue_on_next   = issue_on_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wdata       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (pos_reg == LAST_POS)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_addr_next = '0;
                    state_next    = S_RESP;
                    unique case (operation)
                        OP_MAP:
                        begin
                            if ((virtual_address[11:0] != 12'd0) || (req_count == '0))
                            begin
                                res_status_next = ST_BAD_ARG;
                            end
                            else if (out_of_range)
                            begin
                                res_status_next = ST_NO_ROOM;
                            end
                            else
                            begin
                                state_next    = S_WRITE;
                                pos_next      = start_full[IDX_W-1:0];
                                rem_next      = req_count;
                                frame_next    = physical_address[31:12];
                                map_next      = 1'b1;
                                writable_next = writable;
                            end
                        end
                        OP_FREE:
                        begin
                            if (req_count == '0)
                            begin
                                res_status_next = ST_OK;
                            end
                            else if (out_of_range)
                            begin
                                res_status_next = ST_NO_ROOM;
                            end
                            else
                            begin
                                state_next = S_WRITE;
                                pos_next   = start_full[IDX_W-1:0];
                                rem_next   = req_count;
                                map_next   = 1'b0;
                            end
                        end
                        OP_FIND:
                        begin
                            if (req_count == '0)
                            begin
                                res_status_next = ST_BAD_ARG;
                            end
                            else
                            begin
                                state_next     = S_FIND;
                                pos_next       = '0;
                                want_next      = req_count;
                                run_next       = '0;
                                active_next    = 1'b0;
                                eval_dir_next  = '0;
                                eval_page_next = '0;
                                issue_on_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_BAD_ARG;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = map_reg ? {frame_reg, writable_reg, 1'b1} : '0;
                frame_next = frame_reg + FRAME_W'(1);
                rem_next   = rem_reg - CNT_W'(1);
                pos_next   = pos_reg + IDX_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                end
                else if (pos_reg == LAST_POS)
                begin
                    // The range runs past the last entry with pages still to go.
                    res_status_next = ST_NO_ROOM;
                    state_next      = S_RESP;
                end
            end
            S_FIND:
            begin
                // Read issue runs one entry ahead of the evaluation.
                mem_re = issue_on_reg;
                if (issue_on_reg)
                begin
                    if (pos_reg == LAST_POS)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + IDX_W'(1);
                    end
                end
                if (rd_pend_reg)
                begin
                    if (eval_page_reg == PAGE_LAST)
                    begin
                        eval_page_next = '0;
                        eval_dir_next  = eval_dir_reg + FIELD_W'(1);
                    end
                    else
                    begin
                        eval_page_next = eval_page_reg + FIELD_W'(1);
                    end
                    if (!mem_rdata_reg[0])
                    begin
                        run_next    = run_inc;
                        active_next = 1'b1;
                        if (!active_reg)
                        begin
                            start_dir_next  = eval_dir_reg;
                            start_page_next = eval_page_reg;
                        end
                        if (run_inc == want_reg)
                        begin
                            res_status_next = ST_OK;
                            res_addr_next   = active_reg
                                ? {start_dir_reg, start_page_reg, 12'd0}
                                : {eval_dir_reg, eval_page_reg, 12'd0};
                            issue_on_next   = 1'b0;
                            state_next      = S_RESP;
                        end
                    end
                    else
                    begin
                        run_next    = '0;
                        active_next = 1'b0;
                    end
                    if ((state_next == S_FIND) && (eval_dir_reg == DIR_LAST)
                        && (eval_page_reg == PAGE_LAST))
                    begin
                        res_status_next = ST_NO_ROOM;
                        res_addr_next   = '0;
                        issue_on_next   = 1'b0;
                        state_next      = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            pos_reg        <= '0;
            rem_reg        <= '0;
            frame_reg      <= '0;
            map_reg        <= 1'b0;
            writable_reg   <= 1'b0;
            want_reg       <= '0;
            run_reg        <= '0;
            active_reg     <= 1'b0;
            start_dir_reg  <= '0;
            start_page_reg <= '0;
            eval_dir_reg   <= '0;
            eval_page_reg  <= '0;
            issue_on_reg   <= 1'b0;
            rd_pend_reg    <= 1'b0;
            res_status_reg <= ST_OK;
            res_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_addr_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            rem_reg        <= rem_next;
            frame_reg      <= frame_next;
            map_reg        <= map_next;
            writable_reg   <= writable_next;
            want_reg       <= want_next;
            run_reg        <= run_next;
            active_reg     <= active_next;
            start_dir_reg  <= start_dir_next;
            start_page_reg <= start_page_next;
            eval_dir_reg   <= eval_dir_next;
            eval_page_reg  <= eval_page_next;
            issue_on_reg   <= issue_on_next;
            rd_pend_reg    <= mem_re;
            res_status_reg <= res_status_next;
            res_addr_reg   <= res_addr_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
        end
    end

endmodule

/* rtl/ptrm_checker.sv */
`include "page_table_range_manager_assert.svh"

module ptrm_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [ptrm_pkg::STATUS_W-1:0]   status,
    input logic [ptrm_pkg::ADDR_W-1:0]     found_address
);
    import ptrm_pkg::*;

    // A stalled result transaction holds its contents.
    `PTRM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({status, found_address}))

    // Only a successful request carries an address.
    `PTRM_ASSERT_NOW(a_addr_zero, out_valid && (status != ST_OK), found_address == '0)

    // Status is one of the three defined codes.
    `PTRM_ASSERT_NOW(a_status_code, out_valid, status <= ST_NO_ROOM)

    // An accepted request keeps the block busy in the following cycle.
    `PTRM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // A found run starts on a page boundary.
    `PTRM_ASSERT_NOW(a_addr_aligned, out_valid, found_address[11:0] == 12'd0)

endmodule

bind page_table_range_manager ptrm_checker u_ptrm_checker (.*);
